### rtl/core/mtfs_pkg.sv
// Shared types and constants for the move-to-front search list.
// No dependencies; used by every module of the block.
package mtfs_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 4;
    localparam int FILL_W        = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic apply;
    } mtfs_cmd_t;

endpackage

### rtl/core/mtfs_datapath.sv
// Datapath: list storage, parallel key compare, move-to-front shift, result register.
// Depends on mtfs_pkg; driven by mtfs_ctrl through mtfs_pkg::mtfs_cmd_t.
module mtfs_datapath #(
    parameter int DEPTH = mtfs_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mtfs_pkg::mtfs_cmd_t                cmd,
    input  logic                               req_type,
    input  logic signed [mtfs_pkg::VALUE_W-1:0] value,
    output logic [mtfs_pkg::STATUS_W-1:0]      status,
    output logic [mtfs_pkg::POS_W-1:0]         position,
    output logic [mtfs_pkg::FILL_W-1:0]        fill_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [mtfs_pkg::VALUE_W-1:0] entries_reg [DEPTH];
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [DEPTH-1:0]             match_reg;
    logic [DEPTH-1:0]             match_next;
    logic                         req_reg;
    logic [mtfs_pkg::VALUE_W-1:0] value_reg;
    logic [mtfs_pkg::STATUS_W-1:0] status_reg;
    logic [mtfs_pkg::STATUS_W-1:0] status_next;
    logic [mtfs_pkg::POS_W-1:0]   position_reg;
    logic [mtfs_pkg::POS_W-1:0]   position_next;
    logic [mtfs_pkg::FILL_W-1:0]  fill_reg;
    logic [mtfs_pkg::FILL_W-1:0]  fill_next;

    logic             is_insert;
    logic             full;
    logic             any_hit;
    logic [IDX_W-1:0] hit_idx;
    logic             do_shift;
    logic [DEPTH-1:0] shift_en;

    // compare the incoming key against every held entry
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_next[i] = (CNT_W'(i) < count_reg) &&
                            (entries_reg[i] == $unsigned(value));
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign is_insert = (req_reg == mtfs_pkg::REQ_INSERT);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign any_hit   = |match_reg;
    assign do_shift  = is_insert ? !full : any_hit;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            shift_en[i] = is_insert || (IDX_W'(i) <= hit_idx);
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        status_next   = mtfs_pkg::ST_DONE;
        position_next = '0;
        if (is_insert)
        begin
            if (full)
            begin
                status_next = mtfs_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (any_hit)
        begin
            position_next = mtfs_pkg::POS_W'(hit_idx);
        end
        else
        begin
            status_next = mtfs_pkg::ST_MISS;
        end
        fill_next = mtfs_pkg::FILL_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.apply)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            match_reg <= match_next;
            req_reg   <= req_type;
            value_reg <= $unsigned(value);
        end
        if (cmd.apply)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
            fill_reg     <= fill_next;
            if (do_shift)
            begin
                entries_reg[0] <= value_reg;
                for (int i = 1; i < DEPTH; i++)
                begin
                    if (shift_en[i])
                    begin
                        entries_reg[i] <= entries_reg[i-1];
                    end
                end
            end
        end
    end

    assign status     = status_reg;
    assign position   = position_reg;
    assign fill_count = fill_reg;

endmodule

### rtl/core/mtfs_ctrl.sv
// Controller: request sequencing and output register handshake.
// Depends on mtfs_pkg; issues mtfs_pkg::mtfs_cmd_t to mtfs_datapath.
module mtfs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output mtfs_pkg::mtfs_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign cmd.load  = in_valid && in_ready;
    assign cmd.apply = (state_reg == S_APPLY) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (cmd.apply)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // transaction in flight blocks a new load
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.load)
        else $error("load accepted while a transaction is in flight");

    // apply always presents a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> out_valid)
        else $error("applied transaction did not reach the output register");

    // pending result must not be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.apply)
        else $error("result overwritten while still pending");

endmodule

### rtl/core/move_to_front_search_list_core.sv
// Move-to-front search list: an ordered list of up to DEPTH signed 32-bit values,
// front first. An insert puts the value at the front (refused with a full status
// when DEPTH entries are held); a search compares the key against all entries at
// once, reports the position of the first match and moves it to the front. Every
// request gives one result. A request first registers the key and the parallel
// compare, then shifts the list and loads the output register, which waits while
// a result is still pending; the next request is taken while a result waits, but
// not while one is in flight. No clearing pass after reset.
module move_to_front_search_list_core #(
    parameter int DEPTH = mtfs_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic signed [mtfs_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mtfs_pkg::STATUS_W-1:0]       status,
    output logic [mtfs_pkg::POS_W-1:0]          position,
    output logic [mtfs_pkg::FILL_W-1:0]         fill_count
);

    mtfs_pkg::mtfs_cmd_t cmd;

    mtfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mtfs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .value      (value),
        .status     (status),
        .position   (position),
        .fill_count (fill_count)
    );

endmodule
